[src/csp_pkg.sv]
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and codes for the codec script stream parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int MAX_VALUE_BYTES = 4;

  localparam int CFG_COUNT = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_THIRD  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_VALUE    = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_BAD_MAGIC    = 3'd0;
  localparam logic [2:0] ERR_ZERO_SCRIPTS = 3'd1;
  localparam logic [2:0] ERR_ADDR_SIZE    = 3'd2;
  localparam logic [2:0] ERR_ZERO_ENTRIES = 3'd3;
  localparam logic [2:0] ERR_VALUE_COUNT  = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED    = 3'd5;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  error_code;
    logic [7:0]  script_tag;
    logic [7:0]  script_index;
    logic [7:0]  entry_index;
    logic [15:0] register_address;
    logic [7:0]  value_count;
    logic [15:0] delay_ms;
    logic [7:0]  value_index;
    logic [7:0]  value_byte;
    logic        last_of_run;
  } result_t;

endpackage

[src/codec_script_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// codec_script_stream_parser_core
// Byte-wise parser for codec register-script files: checks the magic word,
// walks scripts and entries, and emits one beat per value byte plus
// completion and error beats.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | data_byte, end_of_file
//  out     | out_valid/out_stall| result_kind .. value_byte, last_of_run
//  cfg     | cfg_we             | cfg_index, cfg_data
//
//  One input byte per cycle while in_stall is low. Each byte is parsed in the cycle it is
//  accepted and its results (up to two) land in a three-entry result queue; out shows
//  the queue head the next cycle. A byte that yields two results fills the queue
//  further, so in_stall is high while the queue holds two or more entries.
//  in_stall is a register of the queue fill. Synchronous reset empties the
//  queue and returns the parser to the magic header.
// ----------------------------------------------------------------------------
module codec_script_stream_parser_core #(
  parameter int MAX_VALUE_BYTES = csp_pkg::MAX_VALUE_BYTES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             end_of_file,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       result_kind,
  output logic [2:0]                       error_code,
  output logic [7:0]                       script_tag,
  output logic [7:0]                       script_index,
  output logic [7:0]                       entry_index,
  output logic [15:0]                      register_address,
  output logic [7:0]                       value_count,
  output logic [15:0]                      delay_ms,
  output logic [7:0]                       value_index,
  output logic [7:0]                       value_byte,
  output logic                             last_of_run,
  input  logic                             cfg_we,
  input  logic [csp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [csp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [3:0] PH_MAGIC  = 4'd0;
  localparam logic [3:0] PH_SCOUNT = 4'd1;
  localparam logic [3:0] PH_ASIZE  = 4'd2;
  localparam logic [3:0] PH_SID    = 4'd3;
  localparam logic [3:0] PH_ECOUNT = 4'd4;
  localparam logic [3:0] PH_ADDR   = 4'd5;
  localparam logic [3:0] PH_VCOUNT = 4'd6;
  localparam logic [3:0] PH_DELAY  = 4'd7;
  localparam logic [3:0] PH_VALUES = 4'd8;
  localparam logic [3:0] PH_DONE   = 4'd9;
  localparam logic [3:0] PH_ERROR  = 4'd10;

  localparam logic [7:0] MAX_VCOUNT = 8'(MAX_VALUE_BYTES);

  // configuration
  logic [31:0] magic_first, magic_second, magic_third;

  // parse state
  logic [3:0]  phase, phase_next;
  logic [2:0]  fbc, fbc_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [7:0]  scripts_total, scripts_total_next;
  logic [1:0]  address_bytes, address_bytes_next;
  logic [7:0]  cur_script_tag, cur_script_tag_next;
  logic [7:0]  cur_script_index, cur_script_index_next;
  logic [7:0]  entries_total, entries_total_next;
  logic [7:0]  cur_entry_index, cur_entry_index_next;
  logic [15:0] entry_address, entry_address_next;
  logic [7:0]  entry_value_count, entry_value_count_next;
  logic [15:0] entry_delay, entry_delay_next;
  logic [7:0]  cur_value_index, cur_value_index_next;

  // result queue, entry 0 is the head
  csp_pkg::result_t queue [3];
  csp_pkg::result_t queue_next [3];
  logic [1:0] count, count_next;

  csp_pkg::result_t res [2];
  logic [1:0] res_n;
  logic       accept, pop;
  logic [1:0] base;

  function automatic csp_pkg::result_t plain_result(logic [1:0] kind, logic [2:0] code);
    csp_pkg::result_t r;
    r = '0;
    r.result_kind = kind;
    r.error_code = code;
    return r;
  endfunction

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  always_comb begin
    logic [2:0]  fbc_inc;
    logic [8:0]  vidx_inc, eidx_inc, sidx_inc;
    logic        trunc;
    phase_next             = phase;
    fbc_next               = fbc;
    magic_shift_next       = magic_shift;
    scripts_total_next     = scripts_total;
    address_bytes_next     = address_bytes;
    cur_script_tag_next    = cur_script_tag;
    cur_script_index_next  = cur_script_index;
    entries_total_next     = entries_total;
    cur_entry_index_next   = cur_entry_index;
    entry_address_next     = entry_address;
    entry_value_count_next = entry_value_count;
    entry_delay_next       = entry_delay;
    cur_value_index_next   = cur_value_index;
    res[0] = '0;
    res[1] = '0;
    res_n  = 2'd0;
    fbc_inc  = fbc + 3'd1;
    vidx_inc = {1'b0, cur_value_index} + 9'd1;
    eidx_inc = {1'b0, cur_entry_index} + 9'd1;
    sidx_inc = {1'b0, cur_script_index} + 9'd1;

    unique case (phase)
      PH_MAGIC: begin
        magic_shift_next = {data_byte, magic_shift[31:8]};
        fbc_next = fbc_inc;
        if (fbc_inc >= 3'd4) begin
          fbc_next = 3'd0;
          if (magic_shift_next == magic_first || magic_shift_next == magic_second ||
              magic_shift_next == magic_third) begin
            phase_next = PH_SCOUNT;
          end else begin
            phase_next = PH_ERROR;
            res[0] = plain_result(csp_pkg::KIND_ERROR, csp_pkg::ERR_BAD_MAGIC);
            res_n = 2'd1;
          end
        end
      end
      PH_SCOUNT: begin
        scripts_total_next = data_byte;
        if (data_byte == 8'd0) begin
          phase_next = PH_ERROR;
          res[0] = plain_result(csp_pkg::KIND_ERROR, csp_pkg::ERR_ZERO_SCRIPTS);
          res_n = 2'd1;
        end else begin
          phase_next = PH_ASIZE;
        end
      end
      PH_ASIZE: begin
        if (data_byte == 8'd1 || data_byte == 8'd2) begin
          address_bytes_next = data_byte[1:0];
          cur_script_index_next = 8'd0;
          phase_next = PH_SID;
        end else begin
          phase_next = PH_ERROR;
          res[0] = plain_result(csp_pkg::KIND_ERROR, csp_pkg::ERR_ADDR_SIZE);
          res_n = 2'd1;
        end
      end
      PH_SID: begin
        cur_script_tag_next = data_byte;
        phase_next = PH_ECOUNT;
      end
      PH_ECOUNT: begin
        entries_total_next = data_byte;
        if (data_byte == 8'd0) begin
          phase_next = PH_ERROR;
          res[0] = plain_result(csp_pkg::KIND_ERROR, csp_pkg::ERR_ZERO_ENTRIES);
          res_n = 2'd1;
        end else begin
          cur_entry_index_next = 8'd0;
          fbc_next = 3'd0;
          phase_next = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (fbc == 3'd0) entry_address_next = {8'd0, data_byte};
        else entry_address_next = {data_byte, entry_address[7:0]};
        fbc_next = fbc_inc;
        if (fbc_inc >= {1'b0, address_bytes}) begin
          fbc_next = 3'd0;
          phase_next = PH_VCOUNT;
        end
      end
      PH_VCOUNT: begin
        entry_value_count_next = data_byte;
        fbc_next = 3'd0;
        phase_next = PH_DELAY;
      end
      PH_DELAY: begin
        if (fbc == 3'd0) begin
          entry_delay_next = {8'd0, data_byte};
          fbc_next = 3'd1;
        end else begin
          entry_delay_next = {data_byte, entry_delay[7:0]};
          fbc_next = 3'd0;
          if (entry_value_count < 8'd2 || entry_value_count > MAX_VCOUNT) begin
            phase_next = PH_ERROR;
            res[0] = plain_result(csp_pkg::KIND_ERROR, csp_pkg::ERR_VALUE_COUNT);
            res_n = 2'd1;
          end else begin
            cur_value_index_next = 8'd0;
            phase_next = PH_VALUES;
          end
        end
      end
      PH_VALUES: begin
        res[0].result_kind      = csp_pkg::KIND_VALUE;
        res[0].script_tag       = cur_script_tag;
        res[0].script_index     = cur_script_index;
        res[0].entry_index      = cur_entry_index;
        res[0].register_address = entry_address;
        res[0].value_count      = entry_value_count;
        res[0].delay_ms         = entry_delay;
        res[0].value_index      = cur_value_index;
        res[0].value_byte       = data_byte;
        res_n = 2'd1;
        cur_value_index_next = vidx_inc[7:0];
        if (vidx_inc >= {1'b0, entry_value_count}) begin
          cur_value_index_next = 8'd0;
          cur_entry_index_next = eidx_inc[7:0];
          if (eidx_inc >= {1'b0, entries_total}) begin
            cur_entry_index_next = 8'd0;
            cur_script_index_next = sidx_inc[7:0];
            if (sidx_inc >= {1'b0, scripts_total}) begin
              phase_next = PH_DONE;
              res[1] = plain_result(csp_pkg::KIND_COMPLETE, csp_pkg::ERR_BAD_MAGIC);
              res_n = 2'd2;
            end else begin
              phase_next = PH_SID;
            end
          end else begin
            fbc_next = 3'd0;
            phase_next = PH_ADDR;
          end
        end
      end
      default: ;
    endcase

    trunc = end_of_file && phase_next != PH_DONE && phase_next != PH_ERROR;
    if (trunc) begin
      // at most one result precedes truncation
      res[res_n[0]] = plain_result(csp_pkg::KIND_ERROR, csp_pkg::ERR_TRUNCATED);
      res_n = res_n + 2'd1;
    end
    if (res_n == 2'd2) res[1].last_of_run = 1'b1;
    else res[0].last_of_run = 1'b1;

    if (end_of_file) begin
      phase_next             = PH_MAGIC;
      fbc_next               = 3'd0;
      magic_shift_next       = '0;
      scripts_total_next     = '0;
      address_bytes_next     = '0;
      cur_script_tag_next    = '0;
      cur_script_index_next  = '0;
      entries_total_next     = '0;
      cur_entry_index_next   = '0;
      entry_address_next     = '0;
      entry_value_count_next = '0;
      entry_delay_next       = '0;
      cur_value_index_next   = '0;
    end
  end

  // queue update: shift out the head, then append new results behind what stays
  assign base = count - {1'b0, pop};

  always_comb begin
    queue_next = queue;
    count_next = base;
    if (pop) begin
      queue_next[0] = queue[1];
      queue_next[1] = queue[2];
    end
    if (accept && res_n != 2'd0) begin
      queue_next[base] = res[0];
      if (res_n == 2'd2) queue_next[base + 2'd1] = res[1];
      count_next = base + res_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= 2'd0;
      in_stall <= 1'b0;
    end else begin
      count    <= count_next;
      in_stall <= count_next >= 2'd2;
    end
    queue <= queue_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first  <= '0;
      magic_second <= '0;
      magic_third  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        csp_pkg::CFG_MAGIC_FIRST:  magic_first  <= cfg_data;
        csp_pkg::CFG_MAGIC_SECOND: magic_second <= cfg_data;
        csp_pkg::CFG_MAGIC_THIRD:  magic_third  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_MAGIC;
      fbc               <= '0;
      magic_shift       <= '0;
      scripts_total     <= '0;
      address_bytes     <= '0;
      cur_script_tag    <= '0;
      cur_script_index  <= '0;
      entries_total     <= '0;
      cur_entry_index   <= '0;
      entry_address     <= '0;
      entry_value_count <= '0;
      entry_delay       <= '0;
      cur_value_index   <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      fbc               <= fbc_next;
      magic_shift       <= magic_shift_next;
      scripts_total     <= scripts_total_next;
      address_bytes     <= address_bytes_next;
      cur_script_tag    <= cur_script_tag_next;
      cur_script_index  <= cur_script_index_next;
      entries_total     <= entries_total_next;
      cur_entry_index   <= cur_entry_index_next;
      entry_address     <= entry_address_next;
      entry_value_count <= entry_value_count_next;
      entry_delay       <= entry_delay_next;
      cur_value_index   <= cur_value_index_next;
    end
  end

  assign out_valid        = count != 2'd0;
  assign result_kind      = queue[0].result_kind;
  assign error_code       = queue[0].error_code;
  assign script_tag       = queue[0].script_tag;
  assign script_index     = queue[0].script_index;
  assign entry_index      = queue[0].entry_index;
  assign register_address = queue[0].register_address;
  assign value_count      = queue[0].value_count;
  assign delay_ms         = queue[0].delay_ms;
  assign value_index      = queue[0].value_index;
  assign value_byte       = queue[0].value_byte;
  assign last_of_run      = queue[0].last_of_run;

endmodule

[src/csp_checker.sv]
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks for the codec script stream parser, bound to the core.
// ----------------------------------------------------------------------------
module csp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       result_kind,
  input logic [2:0]                       error_code,
  input logic [7:0]                       script_tag,
  input logic [15:0]                      register_address,
  input logic [7:0]                       value_count,
  input logic [15:0]                      delay_ms,
  input logic [7:0]                       value_index,
  input logic [7:0]                       value_byte,
  input logic                             last_of_run
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) &&
      $stable(value_byte) && $stable(last_of_run))
    else $error("stalled output beat changed");

  // nothing comes out or is refused right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // completion and error beats carry no entry context
  a_plain_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != csp_pkg::KIND_VALUE |->
      script_tag == 8'd0 && value_count == 8'd0 && value_byte == 8'd0 &&
      register_address == 16'd0 && delay_ms == 16'd0)
    else $error("non-value beat carries context");

  // value beats sit inside a valid entry
  a_value_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == csp_pkg::KIND_VALUE |->
      error_code == csp_pkg::ERR_BAD_MAGIC && value_count >= 8'd2 &&
      value_index < value_count)
    else $error("value beat outside its entry");

  // a beat that is not last of its run is a value beat
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> result_kind == csp_pkg::KIND_VALUE)
    else $error("non-value beat ahead of another in one run");

endmodule

bind codec_script_stream_parser_core csp_checker u_csp_checker (.*);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the codec script stream parser: feeds script files
// (well-formed, damaged and noise) with random gaps and stalls, tracks the
// expected beats with an in-bench parser and compares every output field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    ST_MAGIC, ST_SCRIPT_COUNT, ST_ADDR_SIZE, ST_SCRIPT_ID, ST_ENTRY_COUNT,
    ST_ADDR, ST_VALUE_COUNT, ST_DELAY, ST_VALUES, ST_DONE, ST_ERROR
  } parse_state_t;

  typedef enum int {
    FAULT_NONE, FAULT_MAGIC, FAULT_SCRIPTS, FAULT_ASIZE, FAULT_ENTRIES,
    FAULT_VCOUNT, FAULT_CUT, FAULT_NOISE
  } file_fault_t;

  typedef struct {
    logic [7:0] data;
    logic       eof;
  } file_beat_t;

  class script_result_tracker;
    logic [31:0]      magic [3];
    parse_state_t     st;
    logic [2:0]       fcnt;
    logic [31:0]      magic_sr;
    logic [7:0]       stot, sid, sidx, etot, eidx, vcnt, vidx;
    logic [1:0]       addr_bytes;
    logic [15:0]      eaddr, edelay;
    csp_pkg::result_t pending_beats [$];
    int               errors;

    function new();
      magic = '{default: '0};
      errors = 0;
      clear();
    endfunction

    function void clear();
      st = ST_MAGIC;
      fcnt = '0; magic_sr = '0; stot = '0; addr_bytes = '0;
      sid = '0; sidx = '0; etot = '0; eidx = '0;
      eaddr = '0; vcnt = '0; edelay = '0; vidx = '0;
    endfunction

    function void set_magic(logic [csp_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] v);
      case (idx)
        csp_pkg::CFG_MAGIC_FIRST:  magic[0] = v;
        csp_pkg::CFG_MAGIC_SECOND: magic[1] = v;
        csp_pkg::CFG_MAGIC_THIRD:  magic[2] = v;
        default: ;
      endcase
    endfunction

    function csp_pkg::result_t plain_beat(logic [1:0] kind);
      csp_pkg::result_t r;
      r = '0;
      r.result_kind = kind;
      return r;
    endfunction

    function csp_pkg::result_t error_beat(logic [2:0] code);
      csp_pkg::result_t r;
      r = plain_beat(csp_pkg::KIND_ERROR);
      r.error_code = code;
      return r;
    endfunction

    function csp_pkg::result_t value_beat(logic [7:0] b);
      csp_pkg::result_t r;
      r = plain_beat(csp_pkg::KIND_VALUE);
      r.script_tag = sid;
      r.script_index = sidx;
      r.entry_index = eidx;
      r.register_address = eaddr;
      r.value_count = vcnt;
      r.delay_ms = edelay;
      r.value_index = vidx;
      r.value_byte = b;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      csp_pkg::result_t outs [$];
      case (st)
        ST_MAGIC: begin
          magic_sr = {b, magic_sr[31:8]};
          fcnt++;
          if (fcnt >= 4) begin
            fcnt = '0;
            if (magic_sr == magic[0] || magic_sr == magic[1] || magic_sr == magic[2]) begin
              st = ST_SCRIPT_COUNT;
            end else begin
              st = ST_ERROR;
              outs.push_back(error_beat(csp_pkg::ERR_BAD_MAGIC));
            end
          end
        end
        ST_SCRIPT_COUNT: begin
          stot = b;
          if (b == 0) begin
            st = ST_ERROR;
            outs.push_back(error_beat(csp_pkg::ERR_ZERO_SCRIPTS));
          end else begin
            st = ST_ADDR_SIZE;
          end
        end
        ST_ADDR_SIZE: begin
          if (b == 1 || b == 2) begin
            addr_bytes = b[1:0];
            sidx = '0;
            st = ST_SCRIPT_ID;
          end else begin
            st = ST_ERROR;
            outs.push_back(error_beat(csp_pkg::ERR_ADDR_SIZE));
          end
        end
        ST_SCRIPT_ID: begin
          sid = b;
          st = ST_ENTRY_COUNT;
        end
        ST_ENTRY_COUNT: begin
          etot = b;
          if (b == 0) begin
            st = ST_ERROR;
            outs.push_back(error_beat(csp_pkg::ERR_ZERO_ENTRIES));
          end else begin
            eidx = '0;
            fcnt = '0;
            st = ST_ADDR;
          end
        end
        ST_ADDR: begin
          if (fcnt == 0) eaddr = {8'h00, b};
          else eaddr = eaddr | {b, 8'h00};
          fcnt++;
          if (fcnt >= addr_bytes) begin
            fcnt = '0;
            st = ST_VALUE_COUNT;
          end
        end
        ST_VALUE_COUNT: begin
          vcnt = b;
          fcnt = '0;
          st = ST_DELAY;
        end
        ST_DELAY: begin
          if (fcnt == 0) begin
            edelay = {8'h00, b};
            fcnt = 3'd1;
          end else begin
            edelay = edelay | {b, 8'h00};
            fcnt = '0;
            // count is judged only once the delay is complete
            if (vcnt < 2 || vcnt > csp_pkg::MAX_VALUE_BYTES) begin
              st = ST_ERROR;
              outs.push_back(error_beat(csp_pkg::ERR_VALUE_COUNT));
            end else begin
              vidx = '0;
              st = ST_VALUES;
            end
          end
        end
        ST_VALUES: begin
          outs.push_back(value_beat(b));
          vidx++;
          if (vidx >= vcnt) begin
            vidx = '0;
            eidx++;
            if (eidx >= etot) begin
              eidx = '0;
              sidx++;
              if (sidx >= stot) begin
                st = ST_DONE;
                outs.push_back(plain_beat(csp_pkg::KIND_COMPLETE));
              end else begin
                st = ST_SCRIPT_ID;
              end
            end else begin
              fcnt = '0;
              st = ST_ADDR;
            end
          end
        end
        default: ;
      endcase
      if (eof) begin
        if (st != ST_DONE && st != ST_ERROR)
          outs.push_back(error_beat(csp_pkg::ERR_TRUNCATED));
        clear();
      end
      if (outs.size() > 0) outs[outs.size()-1].last_of_run = 1'b1;
      foreach (outs[i]) pending_beats.push_back(outs[i]);
    endfunction

    function void field_cmp(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $error("%s mismatch: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_beat(csp_pkg::result_t got);
      csp_pkg::result_t e;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat, kind %0d code %0d", got.result_kind, got.error_code);
        errors++;
        return;
      end
      e = pending_beats.pop_front();
      field_cmp("result_kind", 32'(e.result_kind), 32'(got.result_kind));
      field_cmp("error_code", 32'(e.error_code), 32'(got.error_code));
      field_cmp("script_tag", 32'(e.script_tag), 32'(got.script_tag));
      field_cmp("script_index", 32'(e.script_index), 32'(got.script_index));
      field_cmp("entry_index", 32'(e.entry_index), 32'(got.entry_index));
      field_cmp("register_address", 32'(e.register_address), 32'(got.register_address));
      field_cmp("value_count", 32'(e.value_count), 32'(got.value_count));
      field_cmp("delay_ms", 32'(e.delay_ms), 32'(got.delay_ms));
      field_cmp("value_index", 32'(e.value_index), 32'(got.value_index));
      field_cmp("value_byte", 32'(e.value_byte), 32'(got.value_byte));
      field_cmp("last_of_run", 32'(e.last_of_run), 32'(got.last_of_run));
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      data_byte;
  logic                            end_of_file;
  logic                            out_valid;
  logic                            out_stall;
  logic [1:0]                      result_kind;
  logic [2:0]                      error_code;
  logic [7:0]                      script_tag;
  logic [7:0]                      script_index;
  logic [7:0]                      entry_index;
  logic [15:0]                     register_address;
  logic [7:0]                      value_count;
  logic [15:0]                     delay_ms;
  logic [7:0]                      value_index;
  logic [7:0]                      value_byte;
  logic                            last_of_run;
  logic                            cfg_we;
  logic [csp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [csp_pkg::CFG_DATA_W-1:0]  cfg_data;

  script_result_tracker sb;
  file_beat_t           file_q [$];
  bit                   calm;

  codec_script_stream_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_file(end_of_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .error_code(error_code),
    .script_tag(script_tag), .script_index(script_index),
    .entry_index(entry_index), .register_address(register_address),
    .value_count(value_count), .delay_ms(delay_ms),
    .value_index(value_index), .value_byte(value_byte),
    .last_of_run(last_of_run),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put(logic [7:0] b);
    file_q.push_back('{b, 1'b0});
  endfunction

  // body of a script file; a zero count or bad address size ends it, a bad value count after its delay
  function automatic void gen_structure(file_fault_t f);
    logic [31:0] mw;
    int ns, asz, ne, nv, hit_s;
    mw = sb.magic[$urandom_range(0, 2)];
    if (f == FAULT_MAGIC) mw = $urandom;
    for (int i = 0; i < 4; i++) put(mw[8*i +: 8]);
    ns = (f == FAULT_SCRIPTS) ? 0 : $urandom_range(1, 3);
    put(ns[7:0]);
    if (ns == 0) return;
    asz = $urandom_range(1, 2);
    if (f == FAULT_ASIZE) begin
      do asz = $urandom_range(0, 255); while (asz == 1 || asz == 2);
    end
    put(asz[7:0]);
    if (f == FAULT_ASIZE) return;
    hit_s = $urandom_range(0, ns - 1);
    for (int s = 0; s < ns; s++) begin
      put(8'($urandom_range(0, 255)));
      ne = (f == FAULT_ENTRIES && s == hit_s) ? 0 : $urandom_range(1, 3);
      put(ne[7:0]);
      if (ne == 0) return;
      for (int e = 0; e < ne; e++) begin
        for (int a = 0; a < asz; a++) put(8'($urandom_range(0, 255)));
        nv = $urandom_range(2, csp_pkg::MAX_VALUE_BYTES);
        if (f == FAULT_VCOUNT && s == hit_s && e == 0) begin
          do nv = $urandom_range(0, 255);
          while (nv >= 2 && nv <= csp_pkg::MAX_VALUE_BYTES);
        end
        put(nv[7:0]);
        put(8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 255)));
        if (nv < 2 || nv > csp_pkg::MAX_VALUE_BYTES) return;
        for (int v = 0; v < nv; v++) put(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  function automatic void gen_file(file_fault_t f);
    int first, cut;
    first = file_q.size();
    if (f == FAULT_NOISE) begin
      repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
    end else begin
      gen_structure(f);
      if (f == FAULT_CUT) begin
        cut = $urandom_range(first, file_q.size() - 2);
        while (file_q.size() > cut + 1) void'(file_q.pop_back());
      end else if (f != FAULT_NONE || $urandom_range(0, 1)) begin
        repeat ($urandom_range(f == FAULT_NONE ? 1 : 0, 4)) put(8'($urandom_range(0, 255)));
      end
    end
    file_q[file_q.size()-1].eof = 1'b1;
  endfunction

  task automatic send_beat(file_beat_t bt);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= bt.data;
    end_of_file <= bt.eof;
    do @(posedge clk); while (in_stall);
    sb.note_byte(bt.data, bt.eof);
  endtask

  task automatic send_file();
    calm = ($urandom_range(0, 4) == 0);
    while (file_q.size() > 0) send_beat(file_q.pop_front());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_magic(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    cfg_we <= 1'b1;
    cfg_index <= csp_pkg::CFG_MAGIC_FIRST;
    cfg_data <= a;
    @(posedge clk);
    sb.set_magic(csp_pkg::CFG_MAGIC_FIRST, a);
    cfg_index <= csp_pkg::CFG_MAGIC_SECOND;
    cfg_data <= b;
    @(posedge clk);
    sb.set_magic(csp_pkg::CFG_MAGIC_SECOND, b);
    cfg_index <= csp_pkg::CFG_MAGIC_THIRD;
    cfg_data <= c;
    @(posedge clk);
    sb.set_magic(csp_pkg::CFG_MAGIC_THIRD, c);
    cfg_we <= 1'b0;
  endtask

  // output side: random stall runs, none while calm
  initial begin
    csp_pkg::result_t got;
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.result_kind = result_kind;
        got.error_code = error_code;
        got.script_tag = script_tag;
        got.script_index = script_index;
        got.entry_index = entry_index;
        got.register_address = register_address;
        got.value_count = value_count;
        got.delay_ms = delay_ms;
        got.value_index = value_index;
        got.value_byte = value_byte;
        got.last_of_run = last_of_run;
        sb.check_beat(got);
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int count, r;
    logic [31:0] m0, m1, m2;
    file_fault_t f;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    end_of_file = 1'b0;
    cfg_we = 1'b0;
    cfg_index = csp_pkg::CFG_MAGIC_FIRST;
    cfg_data = '0;
    calm = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: magic words are zero after reset
    // full file with 2-byte address and extreme fields, eof on its last value
    put(8'h00); put(8'h00); put(8'h00); put(8'h00);
    put(8'h01); put(8'h02); put(8'hFF); put(8'h01);
    put(8'hFF); put(8'hFF); put(8'h04); put(8'hFF); put(8'hFF);
    put(8'h00); put(8'hFF); put(8'hAA); put(8'h55);
    file_q[file_q.size()-1].eof = 1'b1;
    // lone byte cut inside the magic word
    put(8'hFF);
    file_q[file_q.size()-1].eof = 1'b1;
    // bad magic, then a trailing byte ignored up to eof
    put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF); put(8'h00);
    file_q[file_q.size()-1].eof = 1'b1;
    send_file();

    for (int ph = 1; ph <= 5; ph++) begin
      settle();
      case (ph)
        1: begin m0 = 32'hFFFF_FFFF; m1 = 32'h0; m2 = $urandom; end
        3: begin m0 = 32'h0; m1 = 32'h0; m2 = 32'h0; end
        4: begin m0 = 32'hFFFF_FFFF; m1 = 32'hFFFF_FFFF; m2 = 32'hFFFF_FFFF; end
        5: begin m0 = $urandom; m1 = 32'hFFFF_FFFF; m2 = $urandom; end
        default: begin m0 = $urandom; m1 = $urandom; m2 = $urandom; end
      endcase
      write_magic(m0, m1, m2);
      count = 0;
      while (count < 280) begin
        r = $urandom_range(0, 99);
        if (r < 60) f = FAULT_NONE;
        else if (r < 66) f = FAULT_MAGIC;
        else if (r < 70) f = FAULT_SCRIPTS;
        else if (r < 75) f = FAULT_ASIZE;
        else if (r < 80) f = FAULT_ENTRIES;
        else if (r < 86) f = FAULT_VCOUNT;
        else if (r < 96) f = FAULT_CUT;
        else f = FAULT_NOISE;
        gen_file(f);
        count += file_q.size();
        send_file();
      end
    end
    settle();
    repeat (10) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d expected beats never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("codec_script_stream_parser_core test passed");
    end else begin
      $display("codec_script_stream_parser_core test failed");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("codec_script_stream_parser_core test failed");
    $finish;
  end

endmodule

[codec_script_stream_parser_core.f]
src/csp_pkg.sv
src/codec_script_stream_parser_core.sv
src/csp_checker.sv
sim/tb.sv
